FILE: design/channel_tagged_buffer_pool_core_defines.svh
`ifndef CHANNEL_TAGGED_BUFFER_POOL_CORE_DEFINES_SVH
`define CHANNEL_TAGGED_BUFFER_POOL_CORE_DEFINES_SVH

// same-cycle implication
`define CTBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctbp assertion failed");

// next-cycle implication
`define CTBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctbp assertion failed");

`endif

FILE: design/ctbp_pkg.sv
`timescale 1ns / 1ps

package ctbp_pkg;

  localparam int unsigned POOL_DEPTH_DEF = 16;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned ADDR_W         = 32;

  typedef enum logic [1:0] {
    ST_ENTRY = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_BUSY  = 2'd3
  } status_e;

  typedef enum logic {
    REQ_PUT = 1'b0,
    REQ_GET = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [ADDR_W-1:0] addr;
  } slot_t;

  typedef struct packed {
    logic    valid;
    status_e status;
    slot_t   slot;
    logic    last;
  } out_push_t;

endpackage

FILE: design/ctbp_mem.sv
`timescale 1ns / 1ps

module ctbp_mem import ctbp_pkg::*; #(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  slot_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output slot_t         rdata_o
);

  slot_t mem_q [POOL_DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ctbp_scan.sv
`timescale 1ns / 1ps

module ctbp_scan import ctbp_pkg::*; #(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [CH_W-1:0]   channel_i,
  input  logic [ADDR_W-1:0] buf_addr_i,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output slot_t             mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  slot_t             mem_rdata_i,
  input  logic              out_ld_i,
  output out_push_t         push_o
);

  state_e          state_q, state_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [CW-1:0]   iss_q, iss_d;
  logic [CW-1:0]   keep_q, keep_d;
  logic            pend_v_q, pend_v_d;
  logic [CH_W-1:0] pend_ch_q, pend_ch_d;
  logic [CH_W-1:0] tgt_q, tgt_d;
  logic            rv_q, rv_d;
  logic            hold_v_q, hold_v_d;
  slot_t           hold_q, hold_d;
  status_e         fin_q, fin_d;

  logic accept, full, is_put, match, consume, issue, done;

  assign accept  = in_valid_i && in_ready_o;
  assign full    = (fill_q == CW'(POOL_DEPTH));
  assign is_put  = (req_e'(req_type_i) == REQ_PUT);
  assign match   = rv_q && (mem_rdata_i.ch == tgt_q);
  assign consume = rv_q && !(match && hold_v_q && !out_ld_i);
  assign issue   = (state_q == S_SCAN) && (iss_q < fill_q) && (!rv_q || consume);
  assign done    = (state_q == S_SCAN) && (iss_q == fill_q) && !rv_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_put) begin
            if (full) begin
              state_d = S_FLUSH;
            end else if (pend_v_q) begin
              state_d = S_SCAN;
            end
          end else begin
            if (pend_v_q) begin
              state_d = S_FLUSH;
            end else if (fill_q != '0) begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (done) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_ld_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    fill_d      = fill_q;
    iss_d       = iss_q;
    keep_d      = keep_q;
    pend_v_d    = pend_v_q;
    pend_ch_d   = pend_ch_q;
    tgt_d       = tgt_q;
    rv_d        = rv_q;
    hold_v_d    = hold_v_q;
    hold_d      = hold_q;
    fin_d       = fin_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = keep_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = issue;
    mem_raddr_o = iss_q[AW-1:0];
    push_o      = '{valid: 1'b0, status: ST_ENTRY, slot: hold_q, last: 1'b0};
    case (state_q)
      S_IDLE: begin
        iss_d    = '0;
        keep_d   = '0;
        rv_d     = 1'b0;
        hold_v_d = 1'b0;
        if (accept) begin
          if (is_put) begin
            if (full) begin
              hold_d = '{ch: channel_i, addr: buf_addr_i};
              fin_d  = ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = fill_q[AW-1:0];
              mem_wdata_o = '{ch: channel_i, addr: buf_addr_i};
              fill_d      = fill_q + CW'(1);
              if (pend_v_q) begin
                pend_v_d = 1'b0;
                tgt_d    = pend_ch_q;
              end
            end
          end else begin
            if (pend_v_q) begin
              hold_d = '{ch: channel_i, addr: '0};
              fin_d  = ST_BUSY;
            end else if (fill_q == '0) begin
              pend_v_d  = 1'b1;
              pend_ch_d = channel_i;
            end else begin
              tgt_d = channel_i;
            end
          end
        end
      end
      S_SCAN: begin
        if (consume) begin
          if (match) begin
            push_o.valid = hold_v_q;
            hold_d       = mem_rdata_i;
            hold_v_d     = 1'b1;
          end else begin
            mem_we_o = 1'b1;
            keep_d   = keep_q + CW'(1);
          end
        end
        if (issue) begin
          iss_d = iss_q + CW'(1);
        end
        rv_d = issue || (rv_q && !consume);
        if (done) begin
          fill_d = keep_q;
          if (hold_v_q) begin
            fin_d = ST_ENTRY;
          end else begin
            fin_d  = ST_NONE;
            hold_d = '{ch: tgt_q, addr: '0};
          end
        end
      end
      S_FLUSH: begin
        push_o = '{valid: out_ld_i, status: fin_q, slot: hold_q, last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      iss_q     <= '0;
      keep_q    <= '0;
      pend_v_q  <= 1'b0;
      pend_ch_q <= '0;
      rv_q      <= 1'b0;
      hold_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      iss_q     <= iss_d;
      keep_q    <= keep_d;
      pend_v_q  <= pend_v_d;
      pend_ch_q <= pend_ch_d;
      rv_q      <= rv_d;
      hold_v_q  <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q  <= tgt_d;
    hold_q <= hold_d;
    fin_q  <= fin_d;
  end

endmodule

FILE: design/ctbp_out.sv
`timescale 1ns / 1ps

module ctbp_out import ctbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  out_push_t         push_i,
  output logic              ld_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [CH_W-1:0]   out_channel_o,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic              last_o
);

  logic    valid_q;
  status_e status_q;
  slot_t   slot_q;
  logic    last_q;

  assign ld_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i.valid) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      status_q <= push_i.status;
      slot_q   <= push_i.slot;
      last_q   <= push_i.last;
    end
  end

  assign out_valid_o   = valid_q;
  assign status_o      = status_q;
  assign out_channel_o = slot_q.ch;
  assign out_addr_o    = slot_q.addr;
  assign last_o        = last_q;

endmodule

FILE: design/channel_tagged_buffer_pool_core.sv
// Put: written straight into the pool; a put into a full pool or a rejected get also emits one final beat.
// Get: accept, one synchronous memory read per stored slot, read latency, end of scan and
// final beat; a get takes longer while out_ready_i is held low.
// One request at a time; the pool memory's single read port sets the scan rate, and a stalled output can hold the scan.
// Reset clears fill count and pending get; pool memory is not cleared.
`timescale 1ns / 1ps

module channel_tagged_buffer_pool_core import ctbp_pkg::*; #(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [CH_W-1:0]   channel_i,
  input  logic [ADDR_W-1:0] buf_addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [CH_W-1:0]   out_channel_o,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic              last_o
);

  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  logic          mem_we, mem_re, out_ld;
  logic [AW-1:0] mem_waddr, mem_raddr;
  slot_t         mem_wdata, mem_rdata;
  out_push_t     push;

  ctbp_mem #(.POOL_DEPTH(POOL_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ctbp_scan #(.POOL_DEPTH(POOL_DEPTH)) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .channel_i   (channel_i),
    .buf_addr_i  (buf_addr_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .out_ld_i    (out_ld),
    .push_o      (push)
  );

  ctbp_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .ld_o          (out_ld),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_channel_o (out_channel_o),
    .out_addr_o    (out_addr_o),
    .last_o        (last_o)
  );

endmodule

FILE: design/ctbp_checker.sv
`timescale 1ns / 1ps
`include "channel_tagged_buffer_pool_core_defines.svh"

module ctbp_checker import ctbp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [CH_W-1:0]   out_channel_o,
  input logic [ADDR_W-1:0] out_addr_o,
  input logic              last_o
);

  // stalled beat holds
  `CTBP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(out_channel_o) && $stable(out_addr_o) && $stable(last_o))

  // non-entry results are always single, final beats
  `CTBP_ASSERT_IMP(a_single_last, clk_i, rst_ni, out_valid_o && status_o != ST_ENTRY, last_o)

  // a get still owes beats: no new request taken
  `CTBP_ASSERT_IMP(a_busy_mid_get, clk_i, rst_ni, out_valid_o && !last_o, !in_ready_o)

endmodule

bind channel_tagged_buffer_pool_core ctbp_checker u_ctbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .out_channel_o (out_channel_o),
  .out_addr_o    (out_addr_o),
  .last_o        (last_o)
);
